// File: rtl/nps_pkg.sv
// Shared types and constants of the nearest position search block.
// Used by the distance unit and the top level; depends on nothing.
package nps_pkg;

    localparam int COORD_W   = 24;
    localparam int DIFF_W    = 24;
    localparam int SQ_W      = 48;
    localparam int DIST_W    = 50;
    localparam int IDXOUT_W  = 8;
    localparam int COUNT_W   = 9;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int ENTRY_W   = 3 * COORD_W;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Word index of the ref_count register, taken from paddr[2].
    localparam logic REG_REF_COUNT = 1'b0;

    typedef struct packed {
        logic clear;
        logic valid;
        logic first;
        logic last;
    } op_ctrl_t;

    typedef struct packed {
        logic empty;
        logic have;
    } unit_status_t;

endpackage

// File: rtl/nps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the reference position table.
module nps_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/nps_dist_unit.sv
// Shared squared-distance unit: one subtract, one squarer, one accumulator
// and a running minimum, fed one coordinate per cycle. Depends on nps_pkg.
module nps_dist_unit #(
    parameter int IDX_W = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nps_pkg::op_ctrl_t                    ctrl,
    input  logic [IDX_W-1:0]                     op_index,
    input  logic signed [nps_pkg::COORD_W-1:0]   coord_a,
    input  logic signed [nps_pkg::COORD_W-1:0]   coord_b,
    output nps_pkg::unit_status_t                status,
    output logic [IDX_W-1:0]                     best_index,
    output logic [nps_pkg::DIST_W-1:0]           best_dist
);

    logic                          d_valid_reg, d_first_reg, d_last_reg;
    logic [IDX_W-1:0]              d_idx_reg;
    logic [nps_pkg::DIFF_W-1:0]    diff_reg;

    logic                          p_valid_reg, p_first_reg, p_last_reg;
    logic [IDX_W-1:0]              p_idx_reg;
    logic [nps_pkg::SQ_W-1:0]      prod_reg;

    logic                          r_valid_reg;
    logic [IDX_W-1:0]              r_idx_reg;
    logic [nps_pkg::DIST_W-1:0]    acc_reg;

    logic                          have_reg;
    logic [IDX_W-1:0]              best_idx_reg;
    logic [nps_pkg::DIST_W-1:0]    best_reg;

    logic [nps_pkg::COORD_W:0]     sd;
    logic [nps_pkg::COORD_W:0]     mag;
    logic [nps_pkg::DIFF_W-1:0]    diff_next;
    logic [nps_pkg::SQ_W-1:0]      prod_next;
    logic [nps_pkg::DIST_W-1:0]    acc_next;

    // The difference of two 24-bit signed values has a magnitude below 2^24.
    always_comb
    begin
        sd        = {coord_a[nps_pkg::COORD_W-1], coord_a}
                  - {coord_b[nps_pkg::COORD_W-1], coord_b};
        mag       = sd[nps_pkg::COORD_W] ? (~sd + 1'b1) : sd;
        diff_next = mag[nps_pkg::DIFF_W-1:0];
        prod_next = nps_pkg::SQ_W'(diff_reg) * nps_pkg::SQ_W'(diff_reg);
        acc_next  = (p_first_reg ? '0 : acc_reg) + nps_pkg::DIST_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            have_reg    <= 1'b0;
        end
        else
        begin
            d_valid_reg <= ctrl.valid;
            p_valid_reg <= d_valid_reg;
            r_valid_reg <= p_valid_reg && p_last_reg;
            if (ctrl.clear)
            begin
                have_reg <= 1'b0;
            end
            else if (r_valid_reg)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_first_reg <= ctrl.first;
        d_last_reg  <= ctrl.last;
        d_idx_reg   <= op_index;
        diff_reg    <= diff_next;

        p_first_reg <= d_first_reg;
        p_last_reg  <= d_last_reg;
        p_idx_reg   <= d_idx_reg;
        prod_reg    <= prod_next;

        if (p_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        r_idx_reg <= p_idx_reg;

        // Strict less-than keeps the lowest index on equal distances.
        if (ctrl.clear)
        begin
            best_reg     <= '0;
            best_idx_reg <= '0;
        end
        else if (r_valid_reg && (!have_reg || acc_reg < best_reg))
        begin
            best_reg     <= acc_reg;
            best_idx_reg <= r_idx_reg;
        end
    end

    assign status.empty = !d_valid_reg && !p_valid_reg && !r_valid_reg;
    assign status.have  = have_reg;
    assign best_index   = best_idx_reg;
    assign best_dist    = best_reg;

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid_reg |-> $past(p_valid_reg && p_last_reg))
        else $error("distance result without a last coordinate");

    a_have_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (have_reg && !ctrl.clear) |=> have_reg)
        else $error("running minimum lost without a clear");

    a_first_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid_reg && !have_reg && !ctrl.clear) |=> (have_reg && best_reg == $past(acc_reg)))
        else $error("first distance not taken as the minimum");

endmodule

// File: rtl/nearest_position_search_top.sv
// Top level of the nearest position search block: APB register, command
// sequencer, reference table RAM and distance unit. Depends on nps_pkg.

// A load transaction (kind 0) writes one reference entry at the accepting
// edge and leaves busy low. A query transaction (kind 1) raises busy and
// scans entries 0 to min(ref_count, REF_DEPTH)-1 through one shared
// subtract-square-accumulate unit, one coordinate per cycle, the three
// coordinates of each entry passing in turn through the single squarer.
// The result appears on best_index, found and best_distance_sq in the
// cycle in which done is high, a single cycle, and is held until the next
// done; busy is low in that cycle, so the next command can be accepted at
// once. The receiver cannot stall the block. Every entry a query scans
// must have been loaded first.
module nearest_position_search_top #(
    parameter int REF_DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [nps_pkg::PADDR_W-1:0]           paddr,
    input  logic [nps_pkg::PDATA_W-1:0]           pwdata,
    output logic [nps_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready,

    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  kind,
    input  logic [7:0]                            ref_index,
    input  logic signed [nps_pkg::COORD_W-1:0]    pos_x,
    input  logic signed [nps_pkg::COORD_W-1:0]    pos_y,
    input  logic signed [nps_pkg::COORD_W-1:0]    pos_z,

    output logic                                  done,
    output logic [nps_pkg::IDXOUT_W-1:0]          best_index,
    output logic                                  found,
    output logic [nps_pkg::DIST_W-1:0]            best_distance_sq
);

    localparam int AW    = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int CNT_W = $clog2(REF_DEPTH + 1);
    localparam int NW    = (CNT_W > nps_pkg::COUNT_W) ? CNT_W : nps_pkg::COUNT_W;
    localparam int CW    = nps_pkg::COORD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    state_t                         state_reg;
    axis_t                          axis_reg;
    logic [NW-1:0]                  rd_idx_reg;
    logic [NW-1:0]                  limit_reg;
    logic [AW-1:0]                  cur_idx_reg;
    logic signed [CW-1:0]           qx_reg, qy_reg, qz_reg;
    logic [nps_pkg::COUNT_W-1:0]    ref_count_reg;
    logic                           done_reg;
    logic [nps_pkg::IDXOUT_W-1:0]   best_index_reg;
    logic                           found_reg;
    logic [nps_pkg::DIST_W-1:0]     best_dist_reg;

    logic                           accept;
    logic                           cfg_write;
    logic [NW-1:0]                  count_w;
    logic [NW-1:0]                  depth_w;
    logic [NW-1:0]                  n_eff;
    logic [NW-1:0]                  load_idx_w;
    logic                           ram_we;
    logic                           ram_re;
    logic [nps_pkg::ENTRY_W-1:0]    ram_rdata;
    logic signed [CW-1:0]           ref_x, ref_y, ref_z;
    nps_pkg::op_ctrl_t              ctrl;
    nps_pkg::unit_status_t          status;
    logic signed [CW-1:0]           coord_a, coord_b;
    logic [AW-1:0]                  unit_best_idx;
    logic [nps_pkg::DIST_W-1:0]     unit_best_dist;
    logic [NW-1:0]                  best_idx_w;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == nps_pkg::REG_REF_COUNT)
                     ? nps_pkg::PDATA_W'(ref_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg <= '0;
        end
        else if (cfg_write && paddr[2] == nps_pkg::REG_REF_COUNT)
        begin
            ref_count_reg <= pwdata[nps_pkg::COUNT_W-1:0];
        end
    end

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;

    assign count_w    = NW'(ref_count_reg);
    assign depth_w    = NW'(REF_DEPTH);
    assign n_eff      = (count_w > depth_w) ? depth_w : count_w;
    assign load_idx_w = NW'(ref_index);
    assign ram_we     = accept && (kind == nps_pkg::KIND_LOAD) && (load_idx_w < depth_w);

    assign ram_re = (state_reg == S_FETCH)
                 || (state_reg == S_SCAN && axis_reg == AXIS_Z && rd_idx_reg != limit_reg);

    nps_ram #(
        .WIDTH (nps_pkg::ENTRY_W),
        .DEPTH (REF_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_idx_w[AW-1:0]),
        .wdata ({pos_z, pos_y, pos_x}),
        .re    (ram_re),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign ref_x = ram_rdata[CW-1:0];
    assign ref_y = ram_rdata[2*CW-1:CW];
    assign ref_z = ram_rdata[3*CW-1:2*CW];

    always_comb
    begin
        ctrl.clear = accept && (kind == nps_pkg::KIND_QUERY);
        ctrl.valid = (state_reg == S_SCAN);
        ctrl.first = (axis_reg == AXIS_X);
        ctrl.last  = (axis_reg == AXIS_Z);
        unique case (axis_reg)
            AXIS_X:
            begin
                coord_a = qx_reg;
                coord_b = ref_x;
            end
            AXIS_Y:
            begin
                coord_a = qy_reg;
                coord_b = ref_y;
            end
            AXIS_Z:
            begin
                coord_a = qz_reg;
                coord_b = ref_z;
            end
            default:
            begin
                coord_a = qz_reg;
                coord_b = ref_z;
            end
        endcase
    end

    nps_dist_unit #(
        .IDX_W (AW)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .op_index   (cur_idx_reg),
        .coord_a    (coord_a),
        .coord_b    (coord_b),
        .status     (status),
        .best_index (unit_best_idx),
        .best_dist  (unit_best_dist)
    );

    assign best_idx_w = NW'(unit_best_idx);

    // Sequencer: one read per entry, then its x, y and z coordinates in turn;
    // the read of the next entry is issued in the z cycle of the current one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            axis_reg       <= AXIS_X;
            rd_idx_reg     <= '0;
            done_reg       <= 1'b0;
            best_index_reg <= '0;
            found_reg      <= 1'b0;
            best_dist_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && kind == nps_pkg::KIND_QUERY)
                    begin
                        rd_idx_reg <= '0;
                        axis_reg   <= AXIS_X;
                        state_reg  <= (n_eff == '0) ? S_DRAIN : S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    axis_reg   <= AXIS_X;
                    state_reg  <= S_SCAN;
                end
                S_SCAN:
                begin
                    unique case (axis_reg)
                        AXIS_X:  axis_reg <= AXIS_Y;
                        AXIS_Y:  axis_reg <= AXIS_Z;
                        default:
                        begin
                            axis_reg <= AXIS_X;
                            if (rd_idx_reg != limit_reg)
                            begin
                                rd_idx_reg <= rd_idx_reg + 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_DRAIN;
                            end
                        end
                    endcase
                end
                S_DRAIN:
                begin
                    if (status.empty)
                    begin
                        done_reg       <= 1'b1;
                        best_index_reg <= best_idx_w[nps_pkg::IDXOUT_W-1:0];
                        found_reg      <= status.have;
                        best_dist_reg  <= unit_best_dist;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && kind == nps_pkg::KIND_QUERY)
        begin
            qx_reg    <= pos_x;
            qy_reg    <= pos_y;
            qz_reg    <= pos_z;
            limit_reg <= n_eff;
        end
        if (ram_re)
        begin
            cur_idx_reg <= rd_idx_reg[AW-1:0];
        end
    end

    assign done             = done_reg;
    assign best_index       = best_index_reg;
    assign found            = found_reg;
    assign best_distance_sq = best_dist_reg;

    a_done_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("query finished without a result strobe");

    a_done_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(state_reg == S_DRAIN)))
        else $error("result strobe outside the end of a query");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (rd_idx_reg <= limit_reg && rd_idx_reg != '0))
        else $error("scan index outside the searched range");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for nearest_position_search_top: a directed table,
// then random phases over several ref_count settings. Depends on nps_pkg.
// Results are matched to a behavioral nearest search here or to fixed answers.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W  = nps_pkg::COORD_W;
    localparam int DIST_W   = nps_pkg::DIST_W;
    localparam int IDXOUT_W = nps_pkg::IDXOUT_W;
    localparam int COUNT_W  = nps_pkg::COUNT_W;
    localparam int PADDR_W  = nps_pkg::PADDR_W;
    localparam int PDATA_W  = nps_pkg::PDATA_W;

    localparam int DEPTH = 256;
    localparam int TIMEOUT_CYCLES = 6_000_000;
    // The tail wait is sized to cover a query of a full table.
    localparam int TAIL_CYCLES = 3 * DEPTH + 16;
    localparam logic [PADDR_W-1:0] ADDR_REF_COUNT = {nps_pkg::REG_REF_COUNT, 2'b00};
    localparam logic signed [COORD_W-1:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] CMIN = 24'sh800000;
    localparam logic [DIST_W-1:0] DIST_FULL = 50'd844424829468675;

    typedef struct packed {
        logic [IDXOUT_W-1:0] idx;
        logic                found;
        logic [DIST_W-1:0]   dist_sq;
    } nearest_t;

    typedef enum {ROW_CFG, ROW_CMD} row_op_t;

    typedef struct {
        row_op_t                   op;
        int                        count;
        logic                      kind;
        logic [7:0]                idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        bit                        typed;
        nearest_t                  want;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      start;
    logic                      busy;
    logic                      kind;
    logic [7:0]                ref_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      done;
    logic [IDXOUT_W-1:0]       best_index;
    logic                      found;
    logic [DIST_W-1:0]         best_distance_sq;

    // Shadow copy of the reference table and the count register.
    logic signed [COORD_W-1:0] tbl_x [DEPTH];
    logic signed [COORD_W-1:0] tbl_y [DEPTH];
    logic signed [COORD_W-1:0] tbl_z [DEPTH];
    bit                        loaded [DEPTH];
    logic [COUNT_W-1:0]        cur_count;

    nearest_t pending_nearest_q [$];
    dir_row_t dir_rows [$];

    int mismatches = 0;
    int results_checked = 0;
    int loads_sent = 0;
    int queries_sent = 0;
    int settings_used = 0;
    int cycle_count = 0;

    int phase_count [15] = '{4, 1, 16, 7, 40, 2, 64, 0, 128, 9, 256, 3, 511, 300, 5};
    int phase_items [15] = '{150, 160, 150, 160, 200, 160, 180, 60, 120, 200,
                             40, 160, 30, 30, 80};

    nearest_position_search_top #(.REF_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .kind(kind), .ref_index(ref_index),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .done(done), .best_index(best_index), .found(found),
        .best_distance_sq(best_distance_sq)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] sq_delta(input logic signed [COORD_W-1:0] a,
                                             input logic signed [COORD_W-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return 64'(d * d);
    endfunction

    function automatic nearest_t predict_nearest(input logic signed [COORD_W-1:0] x,
                                                 input logic signed [COORD_W-1:0] y,
                                                 input logic signed [COORD_W-1:0] z);
        nearest_t   r;
        logic [63:0] d;
        int          n;
        r = '0;
        n = (cur_count > DEPTH) ? DEPTH : int'(cur_count);
        for (int i = 0; i < n; i++)
        begin
            d = sq_delta(x, tbl_x[i]) + sq_delta(y, tbl_y[i]) + sq_delta(z, tbl_z[i]);
            // Strict compare keeps the lowest index on equal distances.
            if (!r.found || d < 64'(r.dist_sq))
            begin
                r.found = 1'b1;
                r.dist_sq = d[DIST_W-1:0];
                r.idx = i[IDXOUT_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic int loaded_prefix();
        int n;
        n = 0;
        while (n < DEPTH && loaded[n])
            n++;
        return n;
    endfunction

    function automatic int searched_entries();
        return (cur_count > DEPTH) ? DEPTH : int'(cur_count);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return CMAX;
        else if (pick < 10)
            return CMIN;
        else if (pick < 15)
            return COORD_W'($urandom_range(0, 2)) - 24'sd1;
        else if (pick < 60)
            return COORD_W'($urandom());
        else
            return COORD_W'($urandom_range(0, 4095)) - 24'sd2048;
    endfunction

    function automatic void add_row(input row_op_t op, input int count, input logic k,
                                    input logic [7:0] idx,
                                    input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y,
                                    input logic signed [COORD_W-1:0] z,
                                    input bit typed, input int w_idx, input bit w_found,
                                    input logic [DIST_W-1:0] w_dist);
        dir_row_t r;
        r.op = op;
        r.count = count;
        r.kind = k;
        r.idx = idx;
        r.x = x;
        r.y = y;
        r.z = z;
        r.typed = typed;
        r.want.idx = w_idx[IDXOUT_W-1:0];
        r.want.found = w_found;
        r.want.dist_sq = w_dist;
        dir_rows.push_back(r);
    endfunction

    // Drives one command and waits for the accepting edge, then updates the
    // shadow table or queues the expected answer.
    task automatic send_command(input logic k, input logic [7:0] idx,
                                input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y,
                                input logic signed [COORD_W-1:0] z,
                                input bit typed, input nearest_t typed_want);
        @(negedge clk);
        start <= 1'b1;
        kind <= k;
        ref_index <= idx;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        do @(posedge clk); while (busy);
        if (k == nps_pkg::KIND_LOAD)
        begin
            tbl_x[idx] = x;
            tbl_y[idx] = y;
            tbl_z[idx] = z;
            loaded[idx] = 1'b1;
            loads_sent++;
        end
        else
        begin
            pending_nearest_q.push_back(typed ? typed_want : predict_nearest(x, y, z));
            queries_sent++;
        end
    endtask

    task automatic sender_gap(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Holds the sender off until every queued answer has come back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_nearest_q.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_ref_count(input int count);
        logic [PDATA_W-1:0] readback;
        drain_results();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_REF_COUNT;
        pwdata <= PDATA_W'(count);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        cur_count = COUNT_W'(count);
        settings_used++;
        if (readback !== PDATA_W'(cur_count))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ref_count readback: expected %0d, got %0d", cur_count, readback);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        nearest_t want;
        if (rst_n && done)
        begin
            if (pending_nearest_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: index %0d found %0d distance %0d",
                             best_index, found, best_distance_sq);
            end
            else
            begin
                want = pending_nearest_q.pop_front();
                results_checked++;
                if (best_index !== want.idx || found !== want.found
                    || best_distance_sq !== want.dist_sq)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d: expected index %0d found %0d distance %0d,",
                                 results_checked, want.idx, want.found, want.dist_sq,
                                 " got index %0d found %0d distance %0d",
                                 best_index, found, best_distance_sq);
                end
            end
        end
    end

    initial
    begin
        nearest_t                  none;
        dir_row_t                  r;
        int                        n_eff;
        int                        prefix;
        int                        idle_pct;
        int                        j;
        int                        pick;
        logic                      k;
        logic [7:0]                idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;

        none = '0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        start <= 1'b0;
        kind <= nps_pkg::KIND_LOAD;
        ref_index <= '0;
        pos_x <= '0;
        pos_y <= '0;
        pos_z <= '0;
        cur_count = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            loaded[i] = 1'b0;
            tbl_x[i] = '0;
            tbl_y[i] = '0;
            tbl_z[i] = '0;
        end
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Empty search, full-range distance, exact hits, a tie, an overwrite.
        add_row(ROW_CFG, 0, nps_pkg::KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_QUERY, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_QUERY, 255, CMAX, CMIN, -24'sd1, 1, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_LOAD, 0, CMAX, CMAX, CMAX, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_LOAD, 1, CMIN, CMIN, CMIN, 0, 0, 0, 0);
        add_row(ROW_CFG, 1, nps_pkg::KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_QUERY, 0, CMIN, CMIN, CMIN, 1, 0, 1, DIST_FULL);
        add_row(ROW_CMD, 0, nps_pkg::KIND_QUERY, 0, CMAX, CMAX, CMAX, 1, 0, 1, 0);
        add_row(ROW_CFG, 2, nps_pkg::KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_QUERY, 7, CMIN, CMIN, CMIN, 1, 1, 1, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_QUERY, 0, 24'sd1, -24'sd1, 24'sh7FFF00,
                0, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_LOAD, 2, 24'sd256, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_LOAD, 3, -24'sd256, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CFG, 4, nps_pkg::KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_QUERY, 0, 0, 0, 0, 1, 2, 1, 50'd65536);
        add_row(ROW_CMD, 0, nps_pkg::KIND_LOAD, 255, 24'sd1, -24'sd1, 24'sd1, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_QUERY, 0, 0, 0, 0, 1, 0, 1, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_QUERY, 0, 0, 0, 24'sd512, 0, 0, 0, 0);
        add_row(ROW_CMD, 0, nps_pkg::KIND_QUERY, 0, 24'sh123456, 24'shABCDEF, 24'sh800001,
                0, 0, 0, 0);

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            if (r.op == ROW_CFG)
                set_ref_count(r.count);
            else
                send_command(r.kind, r.idx, r.x, r.y, r.z, r.typed, r.want);
        end

        for (int p = 0; p < 15; p++)
        begin
            set_ref_count(phase_count[p]);
            idle_pct = (p < 5) ? 13 : ((p < 10) ? 50 : 0);
            n_eff = searched_entries();
            for (int i = 0; i < phase_items[p]; i++)
            begin
                if (i == phase_items[p] / 2)
                    drain_results();
                prefix = loaded_prefix();
                k = ($urandom_range(0, 99) < 55) ? nps_pkg::KIND_QUERY : nps_pkg::KIND_LOAD;
                // A query may only scan entries that were loaded before.
                if (k == nps_pkg::KIND_QUERY && prefix < n_eff)
                    k = nps_pkg::KIND_LOAD;
                idx = 8'($urandom());
                x = rand_coord();
                y = rand_coord();
                z = rand_coord();
                pick = $urandom_range(0, 99);
                if (k == nps_pkg::KIND_LOAD)
                begin
                    if (prefix < DEPTH && (prefix < n_eff || $urandom_range(0, 1) == 1))
                        idx = 8'(prefix);
                    if (pick < 20 && prefix > 0)
                    begin
                        // A duplicate of an existing entry sets up a tie.
                        j = $urandom_range(0, prefix - 1);
                        x = tbl_x[j];
                        y = tbl_y[j];
                        z = tbl_z[j];
                    end
                end
                else if (n_eff > 0 && pick < 50)
                begin
                    j = $urandom_range(0, n_eff - 1);
                    x = tbl_x[j];
                    y = tbl_y[j];
                    z = tbl_z[j];
                    if (pick >= 10)
                    begin
                        x = x + COORD_W'($urandom_range(0, 15)) - 24'sd8;
                        y = y + COORD_W'($urandom_range(0, 15)) - 24'sd8;
                        z = z + COORD_W'($urandom_range(0, 15)) - 24'sd8;
                    end
                end
                send_command(k, idx, x, y, z, 1'b0, none);
                if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                    sender_gap($urandom_range(1, 12));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_nearest_q.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_nearest_q.size());
            mismatches += pending_nearest_q.size();
        end

        $display("Sent %0d loads and %0d queries across %0d ref_count writes (0 to 511).",
                 loads_sent, queries_sent, settings_used);
        $display("Checked %0d results; %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
